@@ src/mkte_pkg.sv @@
// mkte_pkg: types, key codes and character tables for the multi-tap keypad
// text entry block. Shared by the front, queue, back and top level modules.
// No dependencies.
package mkte_pkg;

    // default depth of the plan queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // reset value of the timeout register
    localparam logic [7:0] TIMEOUT_RESET = 8'd15;

    // lcd codes
    localparam logic [7:0] LCD_CMD_CLEAR = 8'h01;
    localparam logic [7:0] LCD_ADDR_BASE = 8'h80;

    // key codes (row*4 + column)
    localparam logic [3:0] KEY_ONE     = 4'd0;
    localparam logic [3:0] KEY_RIGHT_A = 4'd3;
    localparam logic [3:0] KEY_RIGHT_B = 4'd7;
    localparam logic [3:0] KEY_LEFT    = 4'd11;
    localparam logic [3:0] KEY_STAR    = 4'd12;
    localparam logic [3:0] KEY_ZERO    = 4'd13;
    localparam logic [3:0] KEY_HASH    = 4'd14;
    localparam logic [3:0] KEY_CLEAR   = 4'd15;

    // input item
    typedef struct packed {
        logic       is_tick;
        logic [3:0] key_code;
    } in_item_t;

    // result item
    typedef struct packed {
        logic       is_data;
        logic [7:0] lcd_byte;
        logic       last;
    } out_item_t;

    // one lcd transaction inside a plan
    typedef struct packed {
        logic       is_data;
        logic [7:0] lcd_byte;
    } slot_t;

    // all results caused by one item; res_last is the index of the final one
    typedef struct packed {
        logic [1:0]      res_last;
        slot_t [3:0]     slots;
    } plan_t;

    // symbols of the letter keys 2..9, by digit-2 and tap-1
    localparam logic [0:7][0:4][7:0] LETTER_TABLE = '{
        '{"A", "B", "C", "2", "2"},
        '{"D", "E", "F", "3", "3"},
        '{"G", "H", "I", "4", "4"},
        '{"J", "K", "L", "5", "5"},
        '{"M", "N", "O", "6", "6"},
        '{"P", "Q", "R", "S", "7"},
        '{"T", "U", "V", "8", "8"},
        '{"W", "X", "Y", "Z", "9"}
    };

    // digit of a letter key, zero for every other key
    function automatic logic [3:0] code_digit(input logic [3:0] code);
        logic [3:0] d;
        case (code)
            4'd1:    d = 4'd2;
            4'd2:    d = 4'd3;
            4'd4:    d = 4'd4;
            4'd5:    d = 4'd5;
            4'd6:    d = 4'd6;
            4'd8:    d = 4'd7;
            4'd9:    d = 4'd8;
            4'd10:   d = 4'd9;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

    // character written by the keys 1 * 0 #
    function automatic logic [7:0] key_char(input logic [3:0] code);
        logic [7:0] ch;
        case (code)
            KEY_ONE:  ch = "1";
            KEY_STAR: ch = "*";
            KEY_ZERO: ch = "0";
            default:  ch = "#";
        endcase
        return ch;
    endfunction

endpackage

@@ src/mkte_front.sv @@
// mkte_front: accepts key and tick items, holds the text entry state and
// turns each item into a plan of up to four lcd transactions.
// Depends on mkte_pkg.
module mkte_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  mkte_pkg::in_item_t  in_item,
    input  logic                q_full,
    output logic                q_push,
    output mkte_pkg::plan_t     q_plan
);
    import mkte_pkg::*;

    logic [7:0] timeout_reg;
    logic [6:0] cursor_reg,    cursor_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [3:0] pend_key_reg,  pend_key_next;
    logic [2:0] tap_reg,       tap_next;
    logic [7:0] tick_reg,      tick_next;

    logic       accept;
    logic [2:0] n_res;
    logic [3:0] digit;
    logic [3:0] tap;
    logic [7:0] tick_inc;
    plan_t      plan;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept && (n_res != 3'd0);
    assign q_plan   = plan;

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // entry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_key_reg   <= '0;
            tap_reg        <= '0;
            tick_reg       <= '0;
        end
        else if (accept)
        begin
            cursor_reg     <= cursor_next;
            pend_valid_reg <= pend_valid_next;
            pend_key_reg   <= pend_key_next;
            tap_reg        <= tap_next;
            tick_reg       <= tick_next;
        end
    end

    // classify the item and build its plan
    always_comb
    begin
        cursor_next     = cursor_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        tap_next        = tap_reg;
        tick_next       = tick_reg;
        plan            = '0;
        n_res           = 3'd0;
        digit           = code_digit(in_item.key_code);
        tap             = 4'd1;
        tick_inc        = tick_reg + 8'd1;

        if (in_item.is_tick)
        begin
            // tick: count while pending, commit on timeout
            if (pend_valid_reg)
            begin
                tick_next = tick_inc;
                if (tick_inc >= timeout_reg)
                begin
                    cursor_next = cursor_next + 7'd1;
                    plan.slots[n_res[1:0]] = {1'b0, LCD_ADDR_BASE | {1'b0, cursor_next}};
                    n_res = n_res + 3'd1;
                    pend_valid_next = 1'b0;
                    tap_next  = '0;
                    tick_next = '0;
                end
            end
        end
        else if (digit != 4'd0)
        begin
            // letter key: next symbol on the same key, else commit first
            if (pend_valid_reg && (pend_key_reg == digit))
            begin
                tap = {1'b0, tap_reg} + 4'd1;
                if ((tap > (((digit == 4'd7) || (digit == 4'd9)) ? 4'd5 : 4'd4))
                    || (tap == 4'd0))
                begin
                    tap = 4'd1;
                end
            end
            else if (pend_valid_reg)
            begin
                cursor_next = cursor_next + 7'd1;
                plan.slots[n_res[1:0]] = {1'b0, LCD_ADDR_BASE | {1'b0, cursor_next}};
                n_res = n_res + 3'd1;
            end
            pend_valid_next = 1'b1;
            pend_key_next   = digit;
            tap_next        = tap[2:0];
            tick_next       = '0;
            plan.slots[n_res[1:0]] =
                {1'b1, LETTER_TABLE[3'(digit - 4'd2)][3'(tap - 4'd1)]};
            n_res = n_res + 3'd1;
            plan.slots[n_res[1:0]] = {1'b0, LCD_ADDR_BASE | {1'b0, cursor_next}};
            n_res = n_res + 3'd1;
        end
        else
        begin
            // other keys: commit any pending letter first
            if (pend_valid_reg)
            begin
                cursor_next = cursor_next + 7'd1;
                plan.slots[n_res[1:0]] = {1'b0, LCD_ADDR_BASE | {1'b0, cursor_next}};
                n_res = n_res + 3'd1;
            end
            pend_valid_next = 1'b0;
            tap_next        = '0;
            tick_next       = '0;
            case (in_item.key_code)
                KEY_RIGHT_A, KEY_RIGHT_B:
                begin
                    cursor_next = cursor_next + 7'd1;
                    plan.slots[n_res[1:0]] = {1'b0, LCD_ADDR_BASE | {1'b0, cursor_next}};
                    n_res = n_res + 3'd1;
                end
                KEY_LEFT:
                begin
                    cursor_next = cursor_next - 7'd1;
                    plan.slots[n_res[1:0]] = {1'b0, LCD_ADDR_BASE | {1'b0, cursor_next}};
                    n_res = n_res + 3'd1;
                end
                KEY_CLEAR:
                begin
                    plan.slots[n_res[1:0]] = {1'b0, LCD_CMD_CLEAR};
                    n_res = n_res + 3'd1;
                    cursor_next = '0;
                    plan.slots[n_res[1:0]] = {1'b0, LCD_ADDR_BASE};
                    n_res = n_res + 3'd1;
                end
                default:
                begin
                    plan.slots[n_res[1:0]] = {1'b1, key_char(in_item.key_code)};
                    n_res = n_res + 3'd1;
                    plan.slots[n_res[1:0]] = {1'b0, LCD_ADDR_BASE | {1'b0, cursor_next}};
                    n_res = n_res + 3'd1;
                    cursor_next = cursor_next + 7'd1;
                    plan.slots[n_res[1:0]] = {1'b0, LCD_ADDR_BASE | {1'b0, cursor_next}};
                    n_res = n_res + 3'd1;
                end
            endcase
        end

        plan.res_last = 2'(n_res - 3'd1);
    end

endmodule

@@ src/mkte_queue.sv @@
// mkte_queue: small register queue of plans between front and back.
// Depends on mkte_pkg.
module mkte_queue #(
    parameter int DEPTH = mkte_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mkte_pkg::plan_t   push_plan,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output mkte_pkg::plan_t   head_plan
);
    import mkte_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    plan_t         store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign q_valid   = (count_reg != '0);
    assign head_plan = store_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // plan storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_plan;
        end
    end

endmodule

@@ src/mkte_back.sv @@
// mkte_back: walks the head plan one lcd transaction at a time into the
// output register, marking the final one of each item.
// Depends on mkte_pkg.
module mkte_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  mkte_pkg::plan_t     head_plan,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output mkte_pkg::out_item_t out_item
);
    import mkte_pkg::*;

    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg,  out_item_next;
    logic [1:0] idx_reg,       idx_next;
    logic       load;
    logic       at_last;
    slot_t      cur_slot;

    assign load      = !out_valid_reg || !out_stall;
    assign cur_slot  = head_plan.slots[idx_reg];
    assign at_last   = (idx_reg == head_plan.res_last);
    assign q_pop     = load && q_valid && at_last;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // next output and slot index
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                out_item_next.is_data  = cur_slot.is_data;
                out_item_next.lcd_byte = cur_slot.lcd_byte;
                out_item_next.last     = at_last;
                idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

@@ src/multitap_keypad_text_entry_top.sv @@
// multitap_keypad_text_entry_top: multi-tap keypad text entry to lcd bytes.
// Path: a plan is held in the plan queue, then its results pass through the output register.
// Throughput: one item per cycle in while the plan queue has room; results leave
// at one per cycle while out_stall is low, k results (0 to 4) per item.
// Reset: rst_n clears cursor, pending letter, counters and queue; timeout goes to 15.
// Depends on mkte_pkg, mkte_front, mkte_queue, mkte_back.
module multitap_keypad_text_entry_top #(
    parameter int QUEUE_DEPTH = mkte_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  mkte_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output mkte_pkg::out_item_t out_item
);
    import mkte_pkg::*;

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    plan_t push_plan;
    plan_t head_plan;

    // front: accept and plan
    mkte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_plan   (push_plan)
    );

    // plan queue
    mkte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_plan (push_plan),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .head_plan (head_plan)
    );

    // back: serialize results
    mkte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head_plan (head_plan),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

@@ test/tb_multitap_keypad_text_entry_top.sv @@
// Testbench for multitap_keypad_text_entry_top: drives key presses and ticks,
// predicts the lcd command/data bytes and checks every byte in order.
// Depends on mkte_pkg and the rtl top level only.
`timescale 1ns / 100ps

module tb_multitap_keypad_text_entry_top;

    import mkte_pkg::*;

    // letter keys, named after their letters
    localparam logic [3:0] KEY_ABC  = 4'd1;
    localparam logic [3:0] KEY_DEF  = 4'd2;
    localparam logic [3:0] KEY_GHI  = 4'd4;
    localparam logic [3:0] KEY_JKL  = 4'd5;
    localparam logic [3:0] KEY_MNO  = 4'd6;
    localparam logic [3:0] KEY_PQRS = 4'd8;
    localparam logic [3:0] KEY_TUV  = 4'd9;
    localparam logic [3:0] KEY_WXYZ = 4'd10;

    localparam logic [7:0][3:0] LETTER_KEYS = {KEY_ABC, KEY_DEF, KEY_GHI, KEY_JKL,
                                               KEY_MNO, KEY_PQRS, KEY_TUV, KEY_WXYZ};
    localparam logic [7:0][3:0] OTHER_KEYS = {KEY_ONE, KEY_STAR, KEY_ZERO, KEY_HASH,
                                              KEY_RIGHT_A, KEY_RIGHT_B, KEY_LEFT,
                                              KEY_CLEAR};

    // keeps its own copy of the text entry state and the lcd bytes still due
    class keypad_lcd_tracker;
        bit [7:0]  timeout;
        bit [6:0]  cursor;
        bit        pend;
        int        pend_digit;
        int        taps;
        bit [7:0]  ticks;
        out_item_t lcd_bytes_due[$];
        out_item_t step_bytes[$];
        int        n_bad;

        function void clear_state();
            timeout = TIMEOUT_RESET;
            cursor = '0;
            pend = 1'b0;
            pend_digit = 0;
            taps = 0;
            ticks = '0;
        endfunction

        function int digit_of(logic [3:0] code);
            int d;
            case (code)
                KEY_ABC:  d = 2;
                KEY_DEF:  d = 3;
                KEY_GHI:  d = 4;
                KEY_JKL:  d = 5;
                KEY_MNO:  d = 6;
                KEY_PQRS: d = 7;
                KEY_TUV:  d = 8;
                KEY_WXYZ: d = 9;
                default:  d = 0;
            endcase
            return d;
        endfunction

        // letters then digit of each key, digit repeated for three-letter keys
        function bit [7:0] symbol(int digit, int tap);
            string s;
            case (digit)
                2:       s = "ABC22";
                3:       s = "DEF33";
                4:       s = "GHI44";
                5:       s = "JKL55";
                6:       s = "MNO66";
                7:       s = "PQRS7";
                8:       s = "TUV88";
                default: s = "WXYZ9";
            endcase
            return s[tap - 1];
        endfunction

        function void emit(bit is_data, bit [7:0] b);
            out_item_t o;
            o.is_data = is_data;
            o.lcd_byte = b;
            o.last = 1'b0;
            step_bytes.push_back(o);
        endfunction

        function void emit_addr();
            emit(1'b0, LCD_ADDR_BASE | {1'b0, cursor});
        endfunction

        function void move(int delta);
            cursor = cursor + 7'(delta);
            emit_addr();
        endfunction

        // a pending letter is committed by stepping the cursor past it
        function void commit();
            if (pend)
                move(1);
            pend = 1'b0;
            taps = 0;
            ticks = '0;
        endfunction

        // works out the lcd bytes caused by one accepted item
        function void predict_lcd_bytes(in_item_t it);
            int digit;
            int span;
            int tap;
            out_item_t tail;
            step_bytes.delete();
            if (it.is_tick) begin
                if (pend) begin
                    ticks = ticks + 8'd1;
                    if (ticks >= timeout)
                        commit();
                end
            end else begin
                digit = digit_of(it.key_code);
                if (digit != 0) begin
                    span = (digit == 7 || digit == 9) ? 5 : 4;
                    if (pend && pend_digit == digit) begin
                        tap = taps + 1;
                        if (tap > span)
                            tap = 1;
                    end else begin
                        commit();
                        tap = 1;
                    end
                    pend = 1'b1;
                    pend_digit = digit;
                    taps = tap;
                    ticks = '0;
                    emit(1'b1, symbol(digit, tap));
                    emit_addr();
                end else begin
                    commit();
                    case (it.key_code)
                        KEY_RIGHT_A, KEY_RIGHT_B: move(1);
                        KEY_LEFT: move(-1);
                        KEY_CLEAR:
                        begin
                            emit(1'b0, LCD_CMD_CLEAR);
                            cursor = '0;
                            emit_addr();
                        end
                        default:
                        begin
                            if (it.key_code == KEY_ONE)
                                emit(1'b1, "1");
                            else if (it.key_code == KEY_STAR)
                                emit(1'b1, "*");
                            else if (it.key_code == KEY_ZERO)
                                emit(1'b1, "0");
                            else
                                emit(1'b1, "#");
                            emit_addr();
                            move(1);
                        end
                    endcase
                end
            end
            if (step_bytes.size() > 0) begin
                tail = step_bytes.pop_back();
                tail.last = 1'b1;
                step_bytes.push_back(tail);
            end
            foreach (step_bytes[i])
                lcd_bytes_due.push_back(step_bytes[i]);
        endfunction

        // compares one accepted lcd byte with the oldest one due
        function void check_lcd_byte(out_item_t got);
            out_item_t want;
            if (lcd_bytes_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("lcd byte with nothing due: data=%0b byte=%02h last=%0b",
                             got.is_data, got.lcd_byte, got.last);
                return;
            end
            want = lcd_bytes_due.pop_front();
            if (got.is_data !== want.is_data || got.lcd_byte !== want.lcd_byte ||
                got.last !== want.last) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("lcd byte mismatch: expected data=%0b byte=%02h last=%0b",
                             want.is_data, want.lcd_byte, want.last);
                    $display("                   got      data=%0b byte=%02h last=%0b",
                             got.is_data, got.lcd_byte, got.last);
                end
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [7:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    keypad_lcd_tracker tracker = new;
    int send_idle_pct;
    int recv_idle_pct;
    int items_done;

    multitap_keypad_text_entry_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // lcd side: check accepted bytes, stall at random
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                tracker.check_lcd_byte(out_item);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function in_item_t key_item(logic [3:0] code);
        in_item_t it;
        it.is_tick = 1'b0;
        it.key_code = code;
        return it;
    endfunction

    function in_item_t tick_item();
        in_item_t it;
        it.is_tick = 1'b1;
        it.key_code = 4'($urandom_range(15));
        return it;
    endfunction

    // offer one item, wait for accept, then predict its lcd bytes
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!(it.is_tick && !tracker.pend))
            items_done++;
        tracker.predict_lcd_bytes(it);
    endtask

    // stop sending until every lcd byte due has come, then let the pipe settle
    task automatic wait_lcd_idle();
        in_valid <= 1'b0;
        while (tracker.lcd_bytes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_timeout(logic [7:0] v);
        wait_lcd_idle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.timeout = v;
    endtask

    // one random burst: mostly letter entry with taps and ticks, some other keys
    task automatic send_sequence();
        int r;
        int n;
        logic [3:0] code;
        r = $urandom_range(99);
        if (r < 55) begin
            code = LETTER_KEYS[3'($urandom_range(7))];
            n = $urandom_range(1, 6);
            repeat (n) send_item(key_item(code));
            case ($urandom_range(3))
                0:       n = 0;
                1:       n = tracker.timeout - 1;
                2:       n = tracker.timeout;
                default: n = $urandom_range(1, 3);
            endcase
            if (n > 20)
                n = $urandom_range(1, 6);
            repeat (n) send_item(tick_item());
        end else if (r < 80) begin
            send_item(key_item(OTHER_KEYS[3'($urandom_range(7))]));
        end else if (r < 90) begin
            code = $urandom_range(1) ? KEY_LEFT : KEY_RIGHT_A;
            repeat ($urandom_range(1, 4)) send_item(key_item(code));
        end else begin
            // noise: any field value
            send_item(in_item_t'(5'($urandom_range(31))));
        end
    endtask

    task automatic run_phase(int target, bit long_burst, bit mid_pause);
        int start;
        bit paused;
        start = items_done;
        paused = 1'b0;
        // letter held through a full timeout
        if (long_burst) begin
            send_item(key_item(KEY_WXYZ));
            repeat (tracker.timeout) send_item(tick_item());
        end
        while (items_done - start < target) begin
            if (mid_pause && !paused && items_done - start >= target / 2) begin
                wait_lcd_idle();
                paused = 1'b1;
            end
            send_sequence();
        end
    endtask

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_done = 0;
        tracker.clear_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset timeout, every key, tap wrap, cursor wrap both ways
        send_item(tick_item());
        send_item(key_item(KEY_ONE));
        repeat (5) send_item(key_item(KEY_ABC));
        repeat (6) send_item(key_item(KEY_PQRS));
        send_item(key_item(KEY_WXYZ));
        send_item(key_item(KEY_LEFT));
        send_item(key_item(KEY_RIGHT_A));
        send_item(key_item(KEY_RIGHT_B));
        send_item(key_item(KEY_STAR));
        send_item(key_item(KEY_ZERO));
        send_item(key_item(KEY_HASH));
        send_item(key_item(KEY_CLEAR));
        send_item(key_item(KEY_LEFT));
        send_item(key_item(KEY_RIGHT_A));
        send_item(key_item(KEY_DEF));
        send_item(key_item(KEY_GHI));
        send_item(key_item(KEY_JKL));
        send_item(key_item(KEY_MNO));
        send_item(key_item(KEY_TUV));

        // timeout of zero: first tick while pending commits
        set_timeout(8'd0);
        send_item(key_item(KEY_GHI));
        send_item(tick_item());
        send_item(tick_item());

        set_timeout(8'd4);
        send_idle_pct = 36;
        recv_idle_pct = 56;
        run_phase(80, 1'b0, 1'b1);

        set_timeout(8'd12);
        send_idle_pct = 56;
        recv_idle_pct = 36;
        run_phase(80, 1'b1, 1'b0);

        set_timeout(8'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(80, 1'b0, 1'b0);

        wait_lcd_idle();
        repeat (8) @(posedge clk);
        if (tracker.n_bad == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/mkte_pkg.sv
src/mkte_front.sv
src/mkte_queue.sv
src/mkte_back.sv
src/multitap_keypad_text_entry_top.sv
test/tb_multitap_keypad_text_entry_top.sv
